### rtl/core/bbt_pkg.sv
package bbt_pkg;

   localparam int REGION_BITS    = 20;
   localparam int MIN_BLOCK_BITS = 10;
   localparam int LEVELS         = REGION_BITS - MIN_BLOCK_BITS;
   localparam int NODE_BITS      = LEVELS + 1;
   localparam int DEPTH_BITS     = $clog2(LEVELS + 1);
   localparam int WORDS          = 1 << LEVELS;
   localparam int SIZE_BITS      = 21;
   localparam int OFFSET_BITS    = 20;
   localparam int K_BITS         = $clog2(SIZE_BITS + 1);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOSPACE = 3'd1,
      ST_ZERO    = 3'd2,
      ST_TOOBIG  = 3'd3,
      ST_RANGE   = 3'd4,
      ST_ALIGN   = 3'd5
   } status_type;

   typedef struct packed {
      logic                   opcode;
      logic [SIZE_BITS-1:0]   request_size;
      logic [SIZE_BITS-1:0]   free_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]             status;
      logic [OFFSET_BITS-1:0] block_offset;
   } rsp_type;

endpackage

### rtl/core/bbt_ram.sv
module bbt_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### rtl/core/buddy_bit_tree_allocator.sv
// Buddy allocator over a 1 MiB region in 1 KiB minimum blocks. Issue a request with start
// while busy is low; exactly one response follows on rsp_valid for one cycle and cannot be
// held off. Allocation walks the tree depth first, for each node visited reading the parent
// word, then the node's child word, then deciding, and climbs back up one level at a time
// when backing out of a full subtree; it then marks ancestors with a read and a write per
// level and sets the root mark last. A search over a tree full of minimum blocks can visit
// every node. A free walks up from the leaf with a read and a write per level, clearing
// marks until a marked node still has a marked child or the root is reached. Errors answer
// in the cycle right after the request. The tree lives in a 1024 x 2 RAM, one word of two
// child marks per inner node, with one read and one write port; after reset a clearing pass
// over every word holds busy high.
module buddy_bit_tree_allocator
   import bbt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp
);

   typedef enum logic [10:0] {
      S_CLEAR   = 11'b00000000001,
      S_IDLE    = 11'b00000000010,
      S_VIS_P   = 11'b00000000100,
      S_VIS_N   = 11'b00000001000,
      S_VIS_D   = 11'b00000010000,
      S_ASCEND  = 11'b00000100000,
      S_MARK_RD = 11'b00001000000,
      S_MARK_WR = 11'b00010000000,
      S_FREE_RD = 11'b00100000000,
      S_FREE_WR = 11'b01000000000,
      S_UNUSED  = 11'b10000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [LEVELS-1:0]     clr_ff, clr_in;
   logic                  root_ff, root_in;
   logic [NODE_BITS-1:0]  node_ff, node_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [DEPTH_BITS-1:0] want_ff, want_in;
   logic                  mark_ff, mark_in;
   logic [1:0]            word_ff, word_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  ram_we;
   logic [LEVELS-1:0]     ram_waddr, ram_raddr;
   logic [1:0]            ram_wdata, ram_rdata;

   logic                  accept;
   logic [SIZE_BITS-1:0]  size_m1;
   logic [K_BITS-1:0]     bitlen, k_val;
   logic [1:0]            children, bit_sel;
   logic [NODE_BITS-1:0]  found;
   logic [31:0]           found_wide;
   logic                  cur_mark;

   bbt_ram #(.WIDTH(2), .DEPTH(WORDS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Rounded block exponent: bit length of size minus one, never below the minimum block.
   always_comb begin
      size_m1 = req.request_size - SIZE_BITS'(1);
      bitlen  = '0;
      for (int i = 0; i < SIZE_BITS; i++) begin
         if (size_m1[i]) begin
            bitlen = K_BITS'(i + 1);
         end
      end
      k_val = (bitlen < K_BITS'(MIN_BLOCK_BITS)) ? K_BITS'(MIN_BLOCK_BITS) : bitlen;
   end

   assign children   = (depth_ff == DEPTH_BITS'(LEVELS)) ? 2'b00 : ram_rdata;
   assign bit_sel    = node_ff[0] ? 2'b10 : 2'b01;
   assign cur_mark   = node_ff[0] ? ram_rdata[1] : ram_rdata[0];
   // An unmarked node has a free subtree, so its leftmost descendant at the wanted depth fits.
   assign found      = NODE_BITS'(node_ff << (want_ff - depth_ff));
   assign found_wide = 32'(found) << (REGION_BITS - int'(want_ff));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      root_in      = root_ff;
      node_in      = node_ff;
      depth_in     = depth_ff;
      want_in      = want_ff;
      mark_in      = mark_ff;
      word_in      = word_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = node_ff[LEVELS:1];
      ram_wdata    = 2'b00;
      ram_raddr    = node_ff[LEVELS:1];

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + LEVELS'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               rsp_in.block_offset = '0;
               rsp_in.status       = ST_OK;
               if (req.opcode == OP_ALLOC) begin
                  if (req.request_size == '0) begin
                     rsp_in.status = ST_ZERO;
                     rsp_valid_in  = 1'b1;
                  end else if (k_val > K_BITS'(REGION_BITS)) begin
                     rsp_in.status = ST_TOOBIG;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     want_in  = DEPTH_BITS'(K_BITS'(REGION_BITS) - k_val);
                     node_in  = NODE_BITS'(1);
                     depth_in = '0;
                     state_in = S_VIS_P;
                  end
               end else begin
                  if (req.free_offset[SIZE_BITS-1:REGION_BITS] != '0) begin
                     rsp_in.status = ST_RANGE;
                     rsp_valid_in  = 1'b1;
                  end else if (req.free_offset[MIN_BLOCK_BITS-1:0] != '0) begin
                     rsp_in.status = ST_ALIGN;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     node_in  = {1'b1, req.free_offset[REGION_BITS-1:MIN_BLOCK_BITS]};
                     word_in  = 2'b00;
                     state_in = S_FREE_RD;
                  end
               end
            end
         end
         S_VIS_P: begin
            state_in = S_VIS_N;
         end
         S_VIS_N: begin
            mark_in   = (node_ff == NODE_BITS'(1)) ? root_ff : cur_mark;
            ram_raddr = node_ff[LEVELS-1:0];
            state_in  = S_VIS_D;
         end
         S_VIS_D: begin
            if (!mark_ff) begin
               node_in                = found;
               rsp_in.block_offset    = found_wide[OFFSET_BITS-1:0];
               state_in               = S_MARK_RD;
            end else if (children == 2'b00 || depth_ff == want_ff) begin
               state_in = S_ASCEND;
            end else begin
               node_in  = {node_ff[LEVELS-1:0], 1'b0};
               depth_in = depth_ff + DEPTH_BITS'(1);
               state_in = S_VIS_P;
            end
         end
         S_ASCEND: begin
            if (node_ff == NODE_BITS'(1)) begin
               rsp_in.status = ST_NOSPACE;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (!node_ff[0]) begin
               node_in  = node_ff + NODE_BITS'(1);
               state_in = S_VIS_P;
            end else begin
               node_in  = node_ff >> 1;
               depth_in = depth_ff - DEPTH_BITS'(1);
            end
         end
         S_MARK_RD: begin
            if (node_ff == NODE_BITS'(1)) begin
               root_in      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_MARK_WR;
            end
         end
         S_MARK_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | bit_sel;
            node_in   = node_ff >> 1;
            state_in  = S_MARK_RD;
         end
         S_FREE_RD: begin
            if (node_ff == NODE_BITS'(1)) begin
               if (root_ff && word_ff == 2'b00) begin
                  root_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_FREE_WR;
            end
         end
         S_FREE_WR: begin
            // A marked node that still has a marked child ends the walk.
            if (cur_mark && word_ff != 2'b00) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               ram_we    = cur_mark;
               ram_wdata = ram_rdata & ~bit_sel;
               word_in   = cur_mark ? (ram_rdata & ~bit_sel) : ram_rdata;
               node_in   = node_ff >> 1;
               state_in  = S_FREE_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         root_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff  <= node_in;
      depth_ff <= depth_in;
      want_ff  <= want_in;
      mark_ff  <= mark_in;
      word_ff  <= word_in;
      rsp_ff   <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || accept))
      else $error("response without a request in progress");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VIS_D) |-> (depth_ff <= want_ff))
      else $error("search went below the wanted depth");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> busy)
      else $error("tree write while idle");

   a_ok_on_alloc_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != ST_OK) |-> (rsp.block_offset == '0))
      else $error("nonzero offset on a failed request");
`endif

endmodule

### tb/tb_buddy_bit_tree_allocator.sv
`timescale 1ns / 100ps

module tb_buddy_bit_tree_allocator;
   import bbt_pkg::*;

   localparam int NODES    = 2 << LEVELS;
   localparam int STALL_MAX = 50000;
   localparam int RANDOM_REQUESTS = 1500;

   class alloc_scoreboard;
      bit marks[NODES];
      rsp_type expected_q[$];
      int live_nodes[$];
      int errors;

      function bit marked(int node);
         if (node <= 0 || node >= NODES) return 0;
         return marks[node];
      endfunction

      function bit is_block(int node);
         return marked(node) && !marked(2 * node) && !marked(2 * node + 1);
      endfunction

      // Left-first depth-first search for an unmarked node at the wanted depth.
      function int find_free(int node, int depth, int want);
         int hit;
         if (depth > want || node >= NODES) return 0;
         if (!marked(node) && depth == want) return node;
         if (is_block(node)) return 0;
         hit = find_free(2 * node, depth + 1, want);
         if (hit != 0) return hit;
         return find_free(2 * node + 1, depth + 1, want);
      endfunction

      function void note(req_type r);
         rsp_type e;
         int k, want, node;
         longint unsigned size, off;
         e.status = ST_OK;
         e.block_offset = '0;
         if (r.opcode == OP_ALLOC) begin
            size = r.request_size;
            k = MIN_BLOCK_BITS;
            while ((64'd1 << k) < size) k++;
            if (size == 0) e.status = ST_ZERO;
            else if (k > REGION_BITS) e.status = ST_TOOBIG;
            else begin
               want = REGION_BITS - k;
               node = find_free(1, 0, want);
               if (node == 0) e.status = ST_NOSPACE;
               else begin
                  for (int b = node; b != 0; b >>= 1) marks[b] = 1;
                  e.block_offset = OFFSET_BITS'((longint'(node) - (64'd1 << want)) << k);
                  live_nodes.push_back(node);
               end
            end
         end else begin
            off = r.free_offset;
            if (off >= (64'd1 << REGION_BITS)) e.status = ST_RANGE;
            else if (off[MIN_BLOCK_BITS-1:0] != 0) e.status = ST_ALIGN;
            else begin
               node = (1 << LEVELS) + int'(off >> MIN_BLOCK_BITS);
               marks[node] = 0;
               // Walk up, clearing marked nodes until one still has a marked child.
               for (int b = node >> 1; b != 0; b >>= 1) begin
                  if (marked(b)) begin
                     if (marked(2 * b) || marked(2 * b + 1)) break;
                     marks[b] = 0;
                  end
               end
            end
         end
         expected_q.push_back(e);
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: response with no request pending: status %0d offset 0x%05h",
                     $time, a.status, a.block_offset);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (a.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.block_offset !== e.block_offset) begin
            $display("%0t: block_offset expected 0x%05h actual 0x%05h",
                     $time, e.block_offset, a.block_offset);
            errors++;
         end
      endfunction

      // Returns the offset of some block that is still allocated, or -1 if none.
      function longint pick_live();
         int i, node, depth;
         while (live_nodes.size() > 0) begin
            i = $urandom_range(live_nodes.size() - 1);
            node = live_nodes[i];
            if (is_block(node)) begin
               depth = $clog2(node + 1) - 1;
               return (longint'(node) - (64'd1 << depth)) << (REGION_BITS - depth);
            end
            live_nodes.delete(i);
         end
         return -1;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   alloc_scoreboard sb;
   int gap_pct;
   int stall_count;

   buddy_bit_tree_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_MAX) begin
         $display("tb_buddy_bit_tree_allocator: done, errors");
         $finish;
      end
   end

   // Drives one request and waits for the edge at which it is taken.
   task automatic issue(req_type r);
      start <= 1'b1;
      req   <= r;
      do @(posedge clock); while (busy);
      sb.note(r);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic alloc(int unsigned size);
      req_type r;
      r.opcode = OP_ALLOC;
      r.request_size = SIZE_BITS'(size);
      r.free_offset = SIZE_BITS'($urandom);
      issue(r);
   endtask

   task automatic free(int unsigned off);
      req_type r;
      r.opcode = OP_FREE;
      r.request_size = SIZE_BITS'($urandom);
      r.free_offset = SIZE_BITS'(off);
      issue(r);
   endtask

   initial begin
      longint off;
      int pick;
      sb = new();
      gap_pct = 31;
      reset = 1'b1;
      start = 1'b0;
      req = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      alloc(0);
      alloc(1);
      alloc(1024);
      alloc(1025);
      alloc(21'h1FFFFF);
      alloc(1 << 20 | 1);
      free(1 << 20);
      free(21'h1FFFFF);
      free(1);
      free(1024 + 512);
      free(0);
      free(5 << 10);
      free(2048);
      free(0);
      alloc(1 << 20);
      alloc(1);
      free(0);
      alloc(1 << 19);
      alloc(1 << 19);
      alloc(1024);
      free(1 << 19);
      free(0);
      free(1023 << 10);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         gap_pct = (n < RANDOM_REQUESTS / 3) ? 31 :
                   (n < 2 * RANDOM_REQUESTS / 3) ? 59 : 0;
         pick = $urandom_range(99);
         if (pick < 8) begin
            if ($urandom_range(1)) alloc($urandom & 21'h1FFFFF);
            else free($urandom & 21'h1FFFFF);
         end else if (pick < 45) begin
            off = sb.pick_live();
            if (off >= 0) free(int'(off));
            else alloc($urandom_range(1, 4096));
         end else if (pick < 90) begin
            alloc($urandom_range(1, 4096));
         end else begin
            alloc($urandom_range(1, 1 << 20));
         end
      end
      start <= 1'b0;

      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("tb_buddy_bit_tree_allocator: done, clean");
      end else begin
         $display("tb_buddy_bit_tree_allocator: done, errors");
      end
      $finish;
   end

endmodule
